### hw/rtl/lfv_pkg.sv
// Shared types, constants and helper functions for the LIN frame validator.
`timescale 1ns / 1ps

package lfv_pkg;

    localparam int MAX_DATA_BYTES = 8;
    localparam int COUNT_WIDTH    = 32;
    localparam int N_STATUS       = 8;

    localparam logic [7:0] SYNC_VALUE = 8'h55;
    localparam logic [7:0] ID_MASK    = 8'h3F;

    localparam logic [3:0] DATA_LENGTH_RESET   = 4'd8;
    localparam logic [7:0] EXPECTED_PID_RESET  = 8'd128;
    localparam logic       ENHANCED_MODE_RESET = 1'b1;

    localparam logic [3:0] POS_MAX = 4'd15;

    typedef enum logic [1:0] {
        REG_DATA_LENGTH   = 2'd0,
        REG_EXPECTED_PID  = 2'd1,
        REG_ENHANCED_MODE = 2'd2,
        REG_UNUSED        = 2'd3
    } t_reg_index;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_OVERFLOW  = 3'd1,
        ST_TRUNCATED = 3'd2,
        ST_OVERLONG  = 3'd3,
        ST_SYNC      = 3'd4,
        ST_PARITY    = 3'd5,
        ST_PID       = 3'd6,
        ST_CHECKSUM  = 3'd7
    } t_status;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       byte_present;
        logic       frame_end;
        logic       overflow_flag;
    } t_item;

    typedef struct packed {
        logic [3:0] data_length;
        logic [7:0] expected_pid;
        logic       enhanced_mode;
    } t_cfg;

    // Eight-bit sum with the carry folded back in.
    function automatic logic [7:0] carry_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s > 9'd255) begin
            s = s - 9'd255;
        end
        return s[7:0];
    endfunction

    // Protected identifier with both parity bits for a six-bit frame ID.
    function automatic logic [7:0] make_pid(input logic [5:0] id);
        logic p0;
        logic p1;
        p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
        p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
        return {p1, p0, id};
    endfunction

    // Data length clamped to the supported range.
    function automatic logic [3:0] eff_length(input logic [3:0] dl);
        logic [3:0] n;
        n = dl;
        if (n == 4'd0) begin
            n = 4'd1;
        end
        if (n > 4'(MAX_DATA_BYTES)) begin
            n = 4'(MAX_DATA_BYTES);
        end
        return n;
    endfunction

endpackage

### hw/rtl/lfv_frame_check.sv
// Per-frame byte classification, running checksum and end-of-frame judgement.
`timescale 1ns / 1ps

module lfv_frame_check
    import lfv_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_status o_status
);

    logic [3:0] r_pos;
    logic       r_sync;
    logic [7:0] r_pid;
    logic [7:0] r_sum;
    logic [7:0] r_chk;

    logic [3:0] n_pos;
    logic       n_sync;
    logic [7:0] n_pid;
    logic [7:0] n_sum;
    logic [7:0] n_chk;

    logic [3:0] len;
    logic [3:0] expect_len;
    logic [7:0] calc;

    always_comb begin
        len    = eff_length(i_cfg.data_length);
        n_pos  = r_pos;
        n_sync = r_sync;
        n_pid  = r_pid;
        n_sum  = r_sum;
        n_chk  = r_chk;
        if (i_item.byte_present) begin
            if (r_pos == 4'd0) begin
                n_sync = (i_item.rx_byte == SYNC_VALUE);
            end else if (r_pos == 4'd1) begin
                n_pid = i_item.rx_byte;
            end else if (r_pos < 4'd2 + len) begin
                n_sum = carry_add(r_sum, i_item.rx_byte);
            end else if (r_pos == 4'd2 + len) begin
                n_chk = i_item.rx_byte;
            end
            if (r_pos < POS_MAX) begin
                n_pos = r_pos + 4'd1;
            end
        end
    end

    always_comb begin
        expect_len = 4'd3 + len;
        calc       = n_sum;
        if (i_cfg.enhanced_mode) begin
            calc = carry_add(n_sum, n_pid);
        end
        calc = ~calc;
        if (i_item.overflow_flag) begin
            o_status = ST_OVERFLOW;
        end else if (n_pos < expect_len) begin
            o_status = ST_TRUNCATED;
        end else if (n_pos > expect_len) begin
            o_status = ST_OVERLONG;
        end else if (!n_sync) begin
            o_status = ST_SYNC;
        end else if (make_pid(n_pid[5:0]) != n_pid) begin
            o_status = ST_PARITY;
        end else if (n_pid != i_cfg.expected_pid) begin
            o_status = ST_PID;
        end else if (calc != n_chk) begin
            o_status = ST_CHECKSUM;
        end else begin
            o_status = ST_OK;
        end
    end

    // The closing word returns all per-frame state to zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_sync <= 1'b0;
            r_pid  <= '0;
            r_sum  <= '0;
            r_chk  <= '0;
        end else if (i_en) begin
            if (i_item.frame_end) begin
                r_pos  <= '0;
                r_sync <= 1'b0;
                r_pid  <= '0;
                r_sum  <= '0;
                r_chk  <= '0;
            end else begin
                r_pos  <= n_pos;
                r_sync <= n_sync;
                r_pid  <= n_pid;
                r_sum  <= n_sum;
                r_chk  <= n_chk;
            end
        end
    end

endmodule

### hw/rtl/lfv_status_counters.sv
// Saturating event counters, one for each frame status.
`timescale 1ns / 1ps

module lfv_status_counters
    import lfv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  t_status     i_status,
    output logic [31:0] o_count
);

    logic [COUNT_WIDTH-1:0] r_count [N_STATUS];
    logic [COUNT_WIDTH-1:0] cur;
    logic [COUNT_WIDTH-1:0] n_count;
    logic [63:0]            wide;

    always_comb begin
        cur     = r_count[i_status];
        n_count = cur;
        if (cur != {COUNT_WIDTH{1'b1}}) begin
            n_count = cur + COUNT_WIDTH'(1);
        end
        wide    = 64'(n_count);
        o_count = wide[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N_STATUS; i++) begin
                r_count[i] <= '0;
            end
        end else if (i_en) begin
            r_count[i_status] <= n_count;
        end
    end

endmodule

### hw/rtl/lin_frame_validator.sv
// Top level of the LIN frame validator: stream ports, register port and output register.
// A result word is loaded into the output register when the closing input word advances out
// of the input register. Throughput: one input word per cycle; the input
// register holds a closing word only while the output register is full and not being taken.
// Reset (synchronous, active low) empties both registers, clears the frame state and
// all status counters, and loads the configuration registers with their default values.
`timescale 1ns / 1ps

module lin_frame_validator
    import lfv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    input  logic [1:0]  s_axis_tuser,   // byte_present, overflow_flag
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // status, status_count, zero fill
);

    t_cfg        r_cfg;
    t_item       r_in;
    logic        r_in_valid;
    logic        r_out_valid;
    t_status     r_out_status;
    logic [31:0] r_out_count;

    t_reg_index  reg_idx;
    logic        cfg_wr;
    logic        advance;
    t_status     status;
    logic [31:0] count;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_index'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        case (reg_idx)
            REG_DATA_LENGTH:   prdata = 32'(r_cfg.data_length);
            REG_EXPECTED_PID:  prdata = 32'(r_cfg.expected_pid);
            REG_ENHANCED_MODE: prdata = 32'(r_cfg.enhanced_mode);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.data_length   <= DATA_LENGTH_RESET;
            r_cfg.expected_pid  <= EXPECTED_PID_RESET;
            r_cfg.enhanced_mode <= ENHANCED_MODE_RESET;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_DATA_LENGTH:   r_cfg.data_length   <= pwdata[3:0];
                REG_EXPECTED_PID:  r_cfg.expected_pid  <= pwdata[7:0];
                REG_ENHANCED_MODE: r_cfg.enhanced_mode <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    // A word that does not close a frame never waits on the output side.
    assign advance       = r_in_valid && (!r_in.frame_end || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.rx_byte       <= s_axis_tdata;
            r_in.byte_present  <= s_axis_tuser[0];
            r_in.frame_end     <= s_axis_tlast;
            r_in.overflow_flag <= s_axis_tuser[1];
        end
    end

    lfv_frame_check u_check (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_status (status)
    );

    lfv_status_counters u_counters (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance && r_in.frame_end),
        .i_status (status),
        .o_count  (count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in.frame_end) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in.frame_end) begin
            r_out_status <= status;
            r_out_count  <= count;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out_count, r_out_status};

`ifndef ASSERT_OFF
    a_no_overrun : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_in.frame_end && r_out_valid && !m_axis_tready |=> r_in_valid)
        else $error("closing word left the input register while the result was stalled");

    a_ready_when_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_in_valid)
        else $error("input side stalled with an empty input register");

    a_count_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_count != 32'd0)
        else $error("reported status count is zero");

    a_result_loaded : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.frame_end |=> r_out_valid)
        else $error("closing word produced no result");
`endif

endmodule
